FILE: rtl/core/vcsp_pkg.sv
// Shared types and constants for the VGM command stream parser.
package vcsp_pkg;

  localparam logic [7:0]  OP_WRITE    = 8'h50;
  localparam logic [7:0]  OP_WAIT_N   = 8'h61;
  localparam logic [7:0]  OP_WAIT_60  = 8'h62;
  localparam logic [7:0]  OP_WAIT_50  = 8'h63;
  localparam logic [15:0] WAIT_60_LEN = 16'd735;
  localparam logic [15:0] WAIT_50_LEN = 16'd882;
  localparam logic [15:0] END_MARK    = 16'h0066;
  localparam logic [7:0]  SKIP_RESET  = 8'd39;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_DATA    = 2'd1,
    PH_WAIT_LO = 2'd2,
    PH_WAIT_HI = 2'd3
  } phase_t;

  typedef struct packed {
    logic        has_cmd;
    kind_t       kind;
    logic [15:0] value;
    logic        has_end;
  } entry_t;

endpackage

FILE: rtl/core/vcsp_front.sv
// Front end: byte intake, skip counter and opcode decode into queue entries.
module vcsp_front
  import vcsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       accept,
  input  logic [7:0] stream_byte,
  input  logic       last_byte,
  output logic       push,
  output entry_t     push_entry
);

  logic [7:0] skip_bytes;
  logic [7:0] skip_count;
  logic [7:0] skip_count_next;
  logic [7:0] wait_low_byte;
  logic [7:0] wait_low_byte_next;
  phase_t     phase;
  phase_t     phase_next;
  logic       skipping;

  assign skipping = skip_count < skip_bytes;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (!skipping) begin
        case (phase)
          PH_OPCODE: begin
            if (stream_byte == OP_WRITE) begin
              phase_next = PH_DATA;
            end else if (stream_byte == OP_WAIT_N) begin
              phase_next = PH_WAIT_LO;
            end
          end
          PH_DATA:    phase_next = PH_OPCODE;
          PH_WAIT_LO: phase_next = PH_WAIT_HI;
          PH_WAIT_HI: phase_next = PH_OPCODE;
          default:    phase_next = PH_OPCODE;
        endcase
      end
      if (last_byte) begin
        phase_next = PH_OPCODE;
      end
    end
  end

  always_comb begin
    push_entry.has_cmd = 1'b0;
    push_entry.kind    = KIND_WRITE;
    push_entry.value   = '0;
    push_entry.has_end = last_byte;
    if (!skipping) begin
      case (phase)
        PH_OPCODE: begin
          if (stream_byte == OP_WAIT_60) begin
            push_entry.has_cmd = 1'b1;
            push_entry.kind    = KIND_WAIT;
            push_entry.value   = WAIT_60_LEN;
          end else if (stream_byte == OP_WAIT_50) begin
            push_entry.has_cmd = 1'b1;
            push_entry.kind    = KIND_WAIT;
            push_entry.value   = WAIT_50_LEN;
          end
        end
        PH_DATA: begin
          push_entry.has_cmd = 1'b1;
          push_entry.kind    = KIND_WRITE;
          push_entry.value   = {8'd0, stream_byte};
        end
        PH_WAIT_HI: begin
          push_entry.has_cmd = 1'b1;
          push_entry.kind    = KIND_WAIT;
          push_entry.value   = {stream_byte, wait_low_byte};
        end
        default: begin
          push_entry.has_cmd = 1'b0;
        end
      endcase
    end
    push = accept && (push_entry.has_cmd || push_entry.has_end);
  end

  always_comb begin
    skip_count_next    = skip_count;
    wait_low_byte_next = wait_low_byte;
    if (accept) begin
      if (skipping) begin
        skip_count_next = skip_count + 8'd1;
      end else if (phase == PH_WAIT_LO) begin
        wait_low_byte_next = stream_byte;
      end
      if (last_byte) begin
        skip_count_next    = '0;
        wait_low_byte_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_bytes    <= SKIP_RESET;
      skip_count    <= '0;
      wait_low_byte <= '0;
      phase         <= PH_OPCODE;
    end else begin
      if (cfg_we) begin
        skip_bytes <= cfg_wdata;
      end
      skip_count    <= skip_count_next;
      wait_low_byte <= wait_low_byte_next;
      phase         <= phase_next;
    end
  end

  a_skip_no_cmd: assert property (@(posedge clk) disable iff (rst)
    accept && skipping |-> !push_entry.has_cmd)
    else $error("command decoded while skipping");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> skip_count == 8'd0 && phase == PH_OPCODE)
    else $error("stream state not cleared after last byte");

endmodule

FILE: rtl/core/vcsp_queue.sv
// Short entry queue between the decode front end and the output back end.
module vcsp_queue
  import vcsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   full,
  output logic   empty
);

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full      = count == QDEPTH[QAW:0];
  assign empty     = count == '0;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

FILE: rtl/core/vcsp_back.sv
// Back end: unpacks queue entries into single output requests.
module vcsp_back
  import vcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  entry_t      pop_entry,
  input  logic        empty,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  entry_t cur;
  logic   cur_valid;
  logic   done;

  assign m_tvalid = cur_valid;
  assign m_tdata  = cur.has_cmd ? cur.value : END_MARK;
  assign m_tuser  = cur.has_cmd ? cur.kind : KIND_END;
  assign m_tlast  = !(cur.has_cmd && cur.has_end);

  assign done = cur_valid && m_tready && m_tlast;
  assign pop  = (!cur_valid || done) && !empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_entry;
    end else if (cur_valid && m_tready && !m_tlast) begin
      cur.has_cmd <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (done) begin
      cur_valid <= 1'b0;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_END |-> m_tlast)
    else $error("end request not marked last");

endmodule

FILE: rtl/core/vgm_command_stream_parser.sv
// Top level of the VGM command stream parser.
// Takes one stream byte per cycle (s_tdata, s_tlast marks the final byte) and, after
// dropping skip_bytes leading bytes (reset 39, set through cfg_we/cfg_wdata while idle),
// emits chip write, wait and end-of-stream requests on the m_ side. A byte enters when
// s_tvalid and s_tready are high; its results leave the output register one per cycle
// while m_tready is high, so a byte that yields both a command and the end marker
// emits the command first and then the end marker. A four-entry queue decouples
// intake from output; input stalls only when that queue is full.
module vgm_command_stream_parser
  import vcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] result_value
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast
);

  logic   accept;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_entry;
  entry_t pop_entry;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  vcsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .stream_byte (s_tdata),
    .last_byte   (s_tlast),
    .push        (push),
    .push_entry  (push_entry)
  );

  vcsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (full),
    .empty      (empty)
  );

  vcsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_entry (pop_entry),
    .empty     (empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: dv/vgm_command_stream_parser_tb.sv
// Self-checking testbench for the VGM command stream parser: random stalls, skip settings.
`timescale 1ns / 100ps

module vgm_command_stream_parser_tb;
  import vcsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int HOLD_AFTER     = 40;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_item_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] value;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  stream_item_t byte_q[$];
  result_t      pending_results[$];
  stream_item_t nxt;
  result_t      exp_r;

  logic [7:0] skip_lim = SKIP_RESET;
  logic [7:0] skipped  = 8'd0;
  phase_t     phase    = PH_OPCODE;
  logic [7:0] wait_lo  = 8'd0;

  int n_queued    = 0;
  int n_issued    = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int idle_cycles = 0;
  int tx_gap      = 0;
  int rx_gap      = 0;
  int rx_seen     = 0;
  bit idle_on     = 1'b1;
  bit hold_done   = 1'b0;

  vgm_command_stream_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("%s", msg);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    result_t r[$];
    if (skipped < skip_lim) begin
      skipped++;
    end else begin
      case (phase)
        PH_OPCODE: begin
          if (b == OP_WRITE) phase = PH_DATA;
          else if (b == OP_WAIT_N) phase = PH_WAIT_LO;
          else if (b == OP_WAIT_60) r = {r, result_t'{KIND_WAIT, WAIT_60_LEN, 1'b0}};
          else if (b == OP_WAIT_50) r = {r, result_t'{KIND_WAIT, WAIT_50_LEN, 1'b0}};
        end
        PH_DATA: begin
          r = {r, result_t'{KIND_WRITE, {8'h00, b}, 1'b0}};
          phase = PH_OPCODE;
        end
        PH_WAIT_LO: begin
          wait_lo = b;
          phase = PH_WAIT_HI;
        end
        PH_WAIT_HI: begin
          r = {r, result_t'{KIND_WAIT, {b, wait_lo}, 1'b0}};
          phase = PH_OPCODE;
        end
      endcase
    end
    if (eos) begin
      r = {r, result_t'{KIND_END, END_MARK, 1'b0}};
      skipped = 8'd0;
      phase = PH_OPCODE;
      wait_lo = 8'd0;
    end
    if (r.size() != 0) r[r.size() - 1].last = 1'b1;
    foreach (r[i]) pending_results = {pending_results, r[i]};
  endtask

  task automatic push_byte(input logic [7:0] b, input logic l);
    byte_q = {byte_q, stream_item_t'{b, l}};
    n_queued++;
  endtask

  task automatic queue_stream(input int n_cmds, input int tail);
    int k;
    repeat (skip_lim) push_byte(8'($urandom), 1'b0);
    repeat (n_cmds) begin
      k = $urandom_range(0, 5);
      case (k)
        0: begin
          push_byte(OP_WRITE, 1'b0);
          push_byte(8'($urandom), 1'b0);
        end
        1: begin
          push_byte(OP_WAIT_N, 1'b0);
          push_byte(8'($urandom), 1'b0);
          push_byte(8'($urandom), 1'b0);
        end
        2: push_byte(OP_WAIT_60, 1'b0);
        3: push_byte(OP_WAIT_50, 1'b0);
        default: push_byte(8'($urandom), 1'b0);
      endcase
    end
    case (tail)
      0: push_byte(OP_WRITE, 1'b1);
      1: begin
        push_byte(OP_WAIT_N, 1'b0);
        push_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
      2: ;
      3: begin
        push_byte(OP_WRITE, 1'b0);
        push_byte(8'($urandom), 1'b1);
      end
      default: push_byte(8'($urandom), 1'b1);
    endcase
  endtask

  task automatic wait_drained;
    while (byte_q.size() != 0 || n_accepted != n_issued || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_skip(input logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    skip_lim = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] skip, input int budget, input bit idle);
    int target;
    write_skip(skip);
    idle_on = idle;
    target = n_queued + budget;
    while (n_queued < target) queue_stream($urandom_range(1, 12), $urandom_range(0, 7));
    wait_drained();
  endtask

  // Driver: offer the next request once the current one is taken and its gap has run out.
  always @(negedge clk) begin
    if (!rst && n_accepted == n_issued) begin
      if (tx_gap != 0) begin
        s_tvalid <= 1'b0;
        tx_gap--;
      end else if (byte_q.size() != 0) begin
        nxt = byte_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= nxt.data;
        s_tlast <= nxt.last;
        n_issued++;
        tx_gap = idle_on ? $urandom_range(0, 3) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall per request, and hold off once for a long stretch.
  always @(negedge clk) begin
    if (!rst) begin
      if (n_results != rx_seen) begin
        rx_seen = n_results;
        rx_gap = idle_on ? $urandom_range(0, 3) : 0;
        if (!hold_done && n_results >= HOLD_AFTER) begin
          rx_gap = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (rx_gap != 0) begin
        m_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        n_accepted++;
        idle_cycles = 0;
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result %0d unexpected: kind %0d value %h last %b",
                               n_results, m_tuser, m_tdata, m_tlast));
        end else begin
          exp_r = pending_results.pop_front();
          if (m_tuser !== exp_r.kind || m_tdata !== exp_r.value || m_tlast !== exp_r.last)
            flag_error($sformatf(
              "result %0d: expected kind %0d value %h last %b, got kind %0d value %h last %b",
              n_results, exp_r.kind, exp_r.value, exp_r.last, m_tuser, m_tdata, m_tlast));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // skip count from reset, then every command with extreme operands
    repeat (SKIP_RESET) push_byte(8'($urandom), 1'b0);
    push_byte(OP_WAIT_60, 1'b0);
    push_byte(OP_WAIT_50, 1'b0);
    push_byte(OP_WRITE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(OP_WRITE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(OP_WAIT_N, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(OP_WAIT_N, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(END_MARK[7:0], 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(OP_WRITE, 1'b0);
    push_byte(8'h5A, 1'b1);
    wait_drained();

    // end during skip, then commands cut off by the final byte
    write_skip(8'd2);
    push_byte(OP_WAIT_60, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(OP_WAIT_N, 1'b0);
    push_byte(8'h34, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(OP_WRITE, 1'b1);
    wait_drained();

    run_phase(8'd0, 80, 1'b1);
    run_phase(8'd255, 1, 1'b0);
    run_phase(8'd1, 120, 1'b1);
    run_phase(8'($urandom_range(4, 12)), 100, 1'b1);
    run_phase(8'd3, 100, 1'b1);

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
